>>> rtl/ist_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants for the interval set table.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int Depth  = 16;
  localparam int IdxW   = 4;
  localparam int CntW   = 5;
  localparam int ValW   = 32;
  localparam int MemAw  = IdxW + 1;

  typedef logic signed [ValW-1:0] val_t;
  typedef logic [IdxW-1:0]        idx_t;
  typedef logic [CntW-1:0]        cnt_t;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_SUB  = 2'd1,
    KIND_TEST = 2'd2,
    KIND_READ = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_FETCH,
    ST_EVAL,
    ST_EMIT2,
    ST_END,
    ST_FINISH,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic rd_en;
    logic eval;
    logic emit2;
    logic step;
    logic final_emit;
    logic commit;
    logic respond;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  empty;
    logic  idx_ok;
    logic  cnt_zero;
    logic  last;
    logic  e2_pend;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/interval_set_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// interval_set_table
// Sorted table of up to sixteen disjoint closed intervals with add, subtract,
// membership test and entry read requests, one result word per request.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Word
//   -------   -------------------   ----------------------------------------
//   in        in_valid / in_ready   kind, interval_low, interval_high,
//                                   probe_value, entry_index
//   out       out_valid / out_ready hit, entry_low, entry_high, entry_valid,
//                                   entry_count, overflow
//
// A request walks the stored entries one at a time; at most one entry needs
// a second write, and each entry needs one read of the entry memory and up
// to two writes into the spare bank. A read fetches only the indexed entry;
// an empty add or subtract, a test on an empty table and a read beyond the
// entry count skip the walk.
// Reset clears the entry count and the bank select; the memory needs no
// clearing since only entries below the count are ever read.
// The result sits in an output register, so a new word is accepted while the
// previous result is still waiting; a stalled output holds the sequencer in
// its response state only when a second result is ready.
//
// Add and subtract stream the current bank into the other bank, merging or
// splitting as they go; the banks swap only when the walk ends without the
// table overflowing, which leaves the set untouched on overflow.
// ----------------------------------------------------------------------------
module interval_set_table (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         kind,
  input  wire logic signed [31:0] interval_low,
  input  wire logic signed [31:0] interval_high,
  input  wire logic signed [31:0] probe_value,
  input  wire logic [3:0]         entry_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    hit,
  output logic signed [31:0]      entry_low,
  output logic signed [31:0]      entry_high,
  output logic                    entry_valid,
  output logic [4:0]              entry_count,
  output logic                    overflow
);

  ist_pkg::cmd_t cmd;
  ist_pkg::sts_t sts;

  // The sequencer issues one command set per cycle.
  ist_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath owns the entry memory and the output register.
  ist_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .kind          (kind),
    .interval_low  (interval_low),
    .interval_high (interval_high),
    .probe_value   (probe_value),
    .entry_index   (entry_index),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .entry_low     (entry_low),
    .entry_high    (entry_high),
    .entry_valid   (entry_valid),
    .entry_count   (entry_count),
    .overflow      (overflow)
  );

endmodule
`default_nettype wire

>>> rtl/ist_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ist_ctrl
// Sequencer that walks the table one entry at a time for each request.
// ----------------------------------------------------------------------------
module ist_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ist_pkg::sts_t sts,
  output ist_pkg::cmd_t      cmd
);

  ist_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ist_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ist_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ist_pkg::ST_START;
        end
      end
      ist_pkg::ST_START: begin
        cmd.start = 1'b1;
        unique case (sts.kind)
          ist_pkg::KIND_ADD, ist_pkg::KIND_SUB: begin
            if (sts.empty) begin
              state_next = ist_pkg::ST_FINISH;
            end else if (sts.cnt_zero) begin
              state_next = ist_pkg::ST_END;
            end else begin
              state_next = ist_pkg::ST_FETCH;
            end
          end
          ist_pkg::KIND_TEST: begin
            state_next = sts.cnt_zero ? ist_pkg::ST_FINISH : ist_pkg::ST_FETCH;
          end
          default: begin
            state_next = sts.idx_ok ? ist_pkg::ST_FETCH : ist_pkg::ST_FINISH;
          end
        endcase
      end
      ist_pkg::ST_FETCH: begin
        cmd.rd_en  = 1'b1;
        state_next = ist_pkg::ST_EVAL;
      end
      ist_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.kind == ist_pkg::KIND_READ) begin
          state_next = ist_pkg::ST_FINISH;
        end else if (sts.e2_pend) begin
          state_next = ist_pkg::ST_EMIT2;
        end else begin
          cmd.step   = 1'b1;
          state_next = sts.last ? ist_pkg::ST_END : ist_pkg::ST_FETCH;
        end
      end
      ist_pkg::ST_EMIT2: begin
        cmd.emit2  = 1'b1;
        cmd.step   = 1'b1;
        state_next = sts.last ? ist_pkg::ST_END : ist_pkg::ST_FETCH;
      end
      ist_pkg::ST_END: begin
        cmd.final_emit = 1'b1;
        state_next     = ist_pkg::ST_FINISH;
      end
      ist_pkg::ST_FINISH: begin
        cmd.commit = 1'b1;
        state_next = ist_pkg::ST_RESP;
      end
      ist_pkg::ST_RESP: begin
        if (sts.out_free) begin
          cmd.respond = 1'b1;
          state_next  = ist_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ist_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/ist_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ist_dp
// Two-bank entry memory, request registers, per-entry rewrite logic and
// the output register.
// ----------------------------------------------------------------------------
module ist_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ist_pkg::cmd_t cmd,
  output ist_pkg::sts_t      sts,
  input  wire logic [1:0]    kind,
  input  wire logic signed [31:0] interval_low,
  input  wire logic signed [31:0] interval_high,
  input  wire logic signed [31:0] probe_value,
  input  wire logic [3:0]    entry_index,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               hit,
  output logic signed [31:0] entry_low,
  output logic signed [31:0] entry_high,
  output logic               entry_valid,
  output logic [4:0]         entry_count,
  output logic               overflow
);

  // Each word holds the lower bound in the upper half and the upper bound below.
  logic [2*ist_pkg::ValW-1:0] mem [2*ist_pkg::Depth];
  logic [2*ist_pkg::ValW-1:0] rdata;

  ist_pkg::kind_t req_kind;
  ist_pkg::val_t  a_pend, b_pend, p_val;
  ist_pkg::idx_t  idx, k;
  ist_pkg::cnt_t  m, count;
  logic           bank, placed, hit_acc, rd_ok, ovf;
  ist_pkg::val_t  rd_lo, rd_hi, e2_lo, e2_hi;

  ist_pkg::val_t  l, h, e1_lo, e1_hi, e2c_lo, e2c_hi, w_lo, w_hi;
  logic           e1v, e2v, outside, we;
  logic [ist_pkg::MemAw-1:0] raddr, waddr;

  assign l = ist_pkg::val_t'(rdata[2*ist_pkg::ValW-1:ist_pkg::ValW]);
  assign h = ist_pkg::val_t'(rdata[ist_pkg::ValW-1:0]);

  assign outside = (h < a_pend) || (l > b_pend);

  always_comb begin
    e1v    = 1'b0;
    e2v    = 1'b0;
    e1_lo  = l;
    e1_hi  = h;
    e2c_lo = l;
    e2c_hi = h;
    unique case (req_kind)
      ist_pkg::KIND_ADD: begin
        e1v = placed || outside;
        if (!placed && (h >= a_pend) && (l > b_pend)) begin
          e1_lo = a_pend;
          e1_hi = b_pend;
          e2v   = 1'b1;
        end
      end
      ist_pkg::KIND_SUB: begin
        e1v = outside || (l < a_pend);
        if (!outside) begin
          e1_hi  = a_pend - ist_pkg::val_t'(1);
          e2v    = h > b_pend;
          e2c_lo = b_pend + ist_pkg::val_t'(1);
        end
      end
      default: begin
        e1v = 1'b0;
      end
    endcase
  end

  always_comb begin
    we   = 1'b0;
    w_lo = e1_lo;
    w_hi = e1_hi;
    if (cmd.eval) begin
      we = e1v;
    end else if (cmd.emit2) begin
      we   = 1'b1;
      w_lo = e2_lo;
      w_hi = e2_hi;
    end else if (cmd.final_emit) begin
      we   = (req_kind == ist_pkg::KIND_ADD) && !placed;
      w_lo = a_pend;
      w_hi = b_pend;
    end
  end

  assign raddr = {bank, (req_kind == ist_pkg::KIND_READ) ? idx : k};
  assign waddr = {~bank, m[ist_pkg::IdxW-1:0]};

  always_ff @(posedge clk) begin
    if (we && !m[ist_pkg::CntW-1]) begin
      mem[waddr] <= {w_lo, w_hi};
    end
    if (cmd.rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // Request registers and walk state.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= ist_pkg::kind_t'(kind);
      a_pend   <= interval_low;
      b_pend   <= interval_high;
      p_val    <= probe_value;
      idx      <= entry_index;
    end
    if (cmd.start) begin
      k       <= '0;
      m       <= '0;
      placed  <= 1'b0;
      hit_acc <= 1'b0;
      ovf     <= 1'b0;
      rd_ok   <= 1'b0;
      rd_lo   <= '0;
      rd_hi   <= '0;
    end
    if (cmd.step) begin
      k <= k + ist_pkg::idx_t'(1);
    end
    if (we) begin
      if (m[ist_pkg::CntW-1]) begin
        ovf <= 1'b1;
      end else begin
        m <= m + ist_pkg::cnt_t'(1);
      end
    end
    if (cmd.eval) begin
      e2_lo <= e2c_lo;
      e2_hi <= e2c_hi;
      unique case (req_kind)
        ist_pkg::KIND_ADD: begin
          if (!placed && !outside) begin
            a_pend <= (l < a_pend) ? l : a_pend;
            b_pend <= (h > b_pend) ? h : b_pend;
          end
          if (!placed && (h >= a_pend) && (l > b_pend)) begin
            placed <= 1'b1;
          end
        end
        ist_pkg::KIND_SUB: begin
          placed <= placed;
        end
        ist_pkg::KIND_TEST: begin
          if ((p_val >= l) && (p_val <= h)) begin
            hit_acc <= 1'b1;
          end
        end
        default: begin
          rd_ok <= 1'b1;
          rd_lo <= l;
          rd_hi <= h;
        end
      endcase
    end
  end

  // Bank select and entry count are the committed table state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank  <= 1'b0;
      count <= '0;
    end else if (cmd.commit && !ovf && !(b_pend < a_pend) &&
                 ((req_kind == ist_pkg::KIND_ADD) || (req_kind == ist_pkg::KIND_SUB))) begin
      bank  <= ~bank;
      count <= m;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.respond) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      hit         <= hit_acc;
      entry_low   <= rd_lo;
      entry_high  <= rd_hi;
      entry_valid <= rd_ok;
      entry_count <= count;
      overflow    <= ovf;
    end
  end

  assign sts.kind     = req_kind;
  assign sts.empty    = b_pend < a_pend;
  assign sts.idx_ok   = {1'b0, idx} < count;
  assign sts.cnt_zero = count == '0;
  assign sts.last     = ({1'b0, k} + ist_pkg::cnt_t'(1)) == count;
  assign sts.e2_pend  = e2v;
  assign sts.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire
